// File: hw/rtl/cfs_pkg.sv
package cfs_pkg;

   localparam int MAX_FRAME_BYTES = 128;
   localparam int FRAME_AW        = $clog2(MAX_FRAME_BYTES);
   localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

   // One frame buffer per job queue slot.
   localparam int JQ_DEPTH = 2;
   localparam int JQ_PW    = $clog2(JQ_DEPTH);
   localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
   localparam int MEM_AW   = JQ_PW + FRAME_AW;

   localparam int BYTE_W = 8;
   localparam int KEPT_W = 8;
   localparam int ID_W   = 8;

   localparam logic [ID_W-1:0] ID_MAX = 8'd254;
   localparam logic [ID_W-1:0] ID_SAT = 8'd255;

   localparam logic [BYTE_W-1:0] CH_M     = "m";
   localparam logic [BYTE_W-1:0] CH_X     = "X";
   localparam logic [BYTE_W-1:0] CH_STAR  = "*";
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_V     = "v";
   localparam logic [BYTE_W-1:0] CH_UA    = "A";
   localparam logic [BYTE_W-1:0] CH_W     = "w";
   localparam logic [BYTE_W-1:0] CH_COLON = ":";
   localparam logic [BYTE_W-1:0] CH_H     = "h";
   localparam logic [BYTE_W-1:0] CH_DASH  = "-";
   localparam logic [BYTE_W-1:0] CH_PLUS  = "+";
   localparam logic [BYTE_W-1:0] CH_C     = "c";
   localparam logic [BYTE_W-1:0] CH_D     = "d";
   localparam logic [BYTE_W-1:0] CH_O     = "o";
   localparam logic [BYTE_W-1:0] CH_T     = "t";
   localparam logic [BYTE_W-1:0] CH_S     = "s";
   localparam logic [BYTE_W-1:0] CH_G     = "g";
   localparam logic [BYTE_W-1:0] CH_LA    = "a";
   localparam logic [BYTE_W-1:0] CH_I     = "i";
   localparam logic [BYTE_W-1:0] CH_0     = "0";
   localparam logic [BYTE_W-1:0] CH_9     = "9";

   typedef struct packed {
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] bare;
      logic             raw;
      logic             ovf;
   } job_type;

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_term(input logic [BYTE_W-1:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

endpackage

// File: hw/rtl/cfs_job_fifo.sv
module cfs_job_fifo import cfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   output logic             full,
   output logic [JQ_PW-1:0] tail_slot,
   input  logic             pop,
   output logic             valid,
   output job_type          head_job,
   output logic [JQ_PW-1:0] head_slot
);

   job_type          slots_ff [JQ_DEPTH];
   logic [JQ_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JQ_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JQ_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JQ_PW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_ff + JQ_PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JQ_PW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_ff + JQ_PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + JQ_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - JQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full      = (count_ff == JQ_CW'(JQ_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_job  = slots_ff[rd_ptr_ff];
   assign head_slot = rd_ptr_ff;
   assign tail_slot = wr_ptr_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < JQ_CW'(JQ_DEPTH)))
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job popped from an empty queue");

endmodule

// File: hw/rtl/cfs_front.sv
module cfs_front import cfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [BYTE_W-1:0] req_frame_byte,
   input  logic              req_last_byte,
   input  logic              req_raw_mode,
   input  logic              q_full,
   input  logic [JQ_PW-1:0]  wr_slot,
   output logic              job_push,
   output job_type           job_out,
   input  logic [MEM_AW-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [2**MEM_AW];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] bare_ff, bare_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             room;
   logic             store;
   logic [CNT_W-1:0] cnt_new;
   logic [CNT_W-1:0] bare_new;
   logic             ovf_new;

   assign accept = req_push && !q_full;
   assign room   = (count_ff < CNT_W'(MAX_FRAME_BYTES));
   assign store  = accept && room;

   // The end of the last byte that is not a terminator is tracked as bytes
   // arrive, so the parser never has to scan backward.
   always_comb begin
      cnt_new  = count_ff;
      bare_new = bare_ff;
      ovf_new  = ovf_ff;
      if (room) begin
         cnt_new = count_ff + CNT_W'(1);
         if (!is_term(req_frame_byte)) begin
            bare_new = count_ff + CNT_W'(1);
         end
      end else begin
         ovf_new = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      bare_in  = bare_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_last_byte) begin
            count_in = '0;
            bare_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = cnt_new;
            bare_in  = bare_new;
            ovf_in   = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bare_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         bare_ff  <= bare_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem[{wr_slot, count_ff[FRAME_AW-1:0]}] <= req_frame_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_full     = q_full;
   assign job_push     = accept && req_last_byte;
   assign job_out.len  = cnt_new;
   assign job_out.bare = bare_new;
   assign job_out.raw  = req_raw_mode;
   assign job_out.ovf  = ovf_new;
   assign rd_data      = rd_data_ff;

endmodule

// File: hw/rtl/cfs_back.sv
module cfs_back import cfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              quiet_time,
   input  logic              job_valid,
   input  job_type           job,
   input  logic [JQ_PW-1:0]  job_slot,
   output logic              job_pop,
   output logic [MEM_AW-1:0] rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [KEPT_W-1:0] rsp_kept_length,
   output logic              rsp_append_newline,
   output logic              rsp_trimmed,
   output logic              rsp_display_motion,
   output logic              rsp_suppressed,
   output logic              rsp_dropped
);

   localparam int ST_W  = 4;
   localparam int ACC_W = 12;

   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_M    = 4'd1;
   localparam logic [ST_W-1:0] S_A1   = 4'd2;
   localparam logic [ST_W-1:0] S_DIG  = 4'd3;
   localparam logic [ST_W-1:0] S_CMD  = 4'd4;
   localparam logic [ST_W-1:0] S_HAFT = 4'd5;
   localparam logic [ST_W-1:0] S_RUN  = 4'd6;
   localparam logic [ST_W-1:0] S_W1   = 4'd7;
   localparam logic [ST_W-1:0] S_W2   = 4'd8;
   localparam logic [ST_W-1:0] S_OUT  = 4'd9;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  kl_ff, kl_in;
   logic [CNT_W-1:0]  dstart_ff, dstart_in;
   logic [ID_W-1:0]   val_ff, val_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic              raw_ff, raw_in;
   logic              wild_ff, wild_in;
   logic              found_ff, found_in;
   logic              hafter_ff, hafter_in;
   logic              drop_ff, drop_in;

   logic              out_valid_ff, out_valid_in;
   logic [KEPT_W-1:0] out_kept_ff;
   logic              out_nl_ff, out_trim_ff, out_motion_ff, out_supp_ff, out_drop_ff;

   logic              at_end;
   logic [CNT_W-1:0]  idx_p1, idx_p2;
   logic [3:0]        dig;
   logic [ACC_W-1:0]  acc;
   logic [ID_W-1:0]   val_next;
   logic [ST_W-1:0]   cmd_next;
   logic [CNT_W-1:0]  cmd_kl;
   logic              load;
   logic              motion;

   assign at_end   = (idx_ff >= len_ff);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign idx_p2   = idx_ff + CNT_W'(2);
   assign dig      = 4'(rd_data - CH_0);
   assign acc      = ACC_W'(val_ff) * ACC_W'(10) + ACC_W'(dig);
   assign val_next = (acc > ACC_W'(ID_SAT)) ? ID_SAT : acc[ID_W-1:0];

   // Known length of a recognized command whose character sits at idx_ff.
   always_comb begin
      cmd_next = S_OUT;
      cmd_kl   = len_ff;
      unique case (rd_data)
         CH_H: begin
            cmd_next = S_HAFT;
            cmd_kl   = idx_p1;
         end
         CH_C, CH_D: begin
            cmd_kl = idx_p1;
         end
         CH_V, CH_UA: begin
            cmd_kl = wild_ff ? len_ff : idx_p1;
         end
         CH_DASH: begin
            cmd_kl = (idx_p1 < len_ff) ? idx_p2 : idx_p1;
         end
         CH_PLUS, CH_O, CH_T, CH_S, CH_G, CH_LA, CH_I: begin
            cmd_next = S_RUN;
         end
         CH_W: begin
            cmd_next = S_W1;
         end
         default: begin
            cmd_next = S_OUT;
         end
      endcase
   end

   assign load = (state_ff == S_OUT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_p1;
      len_in    = len_ff;
      kl_in     = kl_ff;
      dstart_in = dstart_ff;
      val_in    = val_ff;
      cmd_in    = cmd_ff;
      raw_in    = raw_ff;
      wild_in   = wild_ff;
      found_in  = found_ff;
      hafter_in = hafter_ff;
      drop_in   = drop_ff;
      job_pop   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in    = '0;
            found_in  = 1'b0;
            hafter_in = 1'b0;
            wild_in   = 1'b0;
            drop_in   = 1'b0;
            raw_in    = job.raw;
            len_in    = job.raw ? job.len : job.bare;
            kl_in     = job.raw ? job.len : job.bare;
            if (job_valid) begin
               if (job.ovf || (!job.raw && (job.bare == '0))) begin
                  drop_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_M;
               end
            end
         end
         S_M: begin
            state_in = (rd_data == CH_M) ? S_A1 : S_OUT;
         end
         S_A1: begin
            if (at_end || (rd_data == CH_X)) begin
               state_in = S_OUT;
            end else if (rd_data == CH_STAR) begin
               wild_in  = 1'b1;
               state_in = S_CMD;
            end else if (is_digit(rd_data)) begin
               val_in   = ID_W'(dig);
               state_in = S_DIG;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIG, S_CMD: begin
            if (at_end) begin
               state_in = S_OUT;
            end else if ((state_ff == S_DIG) && is_digit(rd_data)) begin
               val_in = val_next;
            end else if ((state_ff == S_DIG) && (val_ff > ID_MAX)) begin
               state_in = S_OUT;
            end else begin
               found_in  = 1'b1;
               cmd_in    = rd_data;
               kl_in     = cmd_kl;
               dstart_in = idx_p1;
               state_in  = cmd_next;
            end
         end
         S_HAFT: begin
            // Outside raw mode the frame is cut right after the home command,
            // so nothing can follow it.
            hafter_in = at_end || !raw_ff || is_term(rd_data);
            state_in  = S_OUT;
         end
         S_RUN, S_W2: begin
            if (at_end || !is_digit(rd_data)) begin
               kl_in    = (idx_ff == dstart_ff) ? len_ff : idx_ff;
               state_in = S_OUT;
            end
         end
         S_W1: begin
            if (at_end || !is_digit(rd_data)) begin
               if (at_end || (idx_ff == dstart_ff) || (rd_data != CH_COLON)) begin
                  kl_in    = len_ff;
                  state_in = S_OUT;
               end else begin
                  dstart_in = idx_p1;
                  state_in  = S_W2;
               end
            end
         end
         S_OUT: begin
            if (load) begin
               job_pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_addr = {job_slot, idx_in[FRAME_AW-1:0]};

   assign motion = found_ff &&
      ((cmd_ff == CH_DASH) || (cmd_ff == CH_PLUS) || ((cmd_ff == CH_H) && hafter_ff));

   assign out_valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      len_ff    <= len_in;
      kl_ff     <= kl_in;
      dstart_ff <= dstart_in;
      val_ff    <= val_in;
      cmd_ff    <= cmd_in;
      raw_ff    <= raw_in;
      wild_ff   <= wild_in;
      found_ff  <= found_in;
      hafter_ff <= hafter_in;
      drop_ff   <= drop_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (drop_ff) begin
            out_kept_ff   <= '0;
            out_nl_ff     <= 1'b0;
            out_trim_ff   <= 1'b0;
            out_motion_ff <= 1'b0;
            out_supp_ff   <= 1'b0;
            out_drop_ff   <= 1'b1;
         end else begin
            out_kept_ff   <= KEPT_W'(raw_ff ? len_ff : kl_ff);
            out_nl_ff     <= !raw_ff && !(found_ff && (cmd_ff == CH_V) && !wild_ff);
            out_trim_ff   <= !raw_ff && (kl_ff < len_ff);
            out_motion_ff <= motion;
            out_supp_ff   <= motion && quiet_time;
            out_drop_ff   <= 1'b0;
         end
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_kept_length    = out_kept_ff;
   assign rsp_append_newline = out_nl_ff;
   assign rsp_trimmed        = out_trim_ff;
   assign rsp_display_motion = out_motion_ff;
   assign rsp_suppressed     = out_supp_ff;
   assign rsp_dropped        = out_drop_ff;

   a_idle_waits_for_job: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && !job_valid) |=> (state_ff == S_IDLE))
      else $error("parser started without a queued frame");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("frame buffer released with no job present");

   a_kept_within_frame: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && !drop_ff) |-> (kl_ff <= len_ff))
      else $error("known command length runs past the frame");

   a_suppress_only_motion: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_suppressed) |-> (rsp_display_motion && !rsp_dropped))
      else $error("suppressed verdict without display motion");

endmodule

// File: hw/rtl/command_frame_sanitizer.sv
// Command frame sanitizer: loads one outbound command frame and returns one verdict for it.
// Input channel: one frame byte per transfer (push/full), with req_last_byte on the final
// byte and req_raw_mode sampled with it. Bytes are taken one per cycle while full is low.
// Result channel (empty/pop): one verdict per frame, held until it is popped.
// Config channel: csr_valid/csr_ready write the quiet time bit; ready is always high.
// Frames are stored in two frame buffers. While one frame is parsed, the next one loads
// into the other buffer; full rises only when both buffers hold frames awaiting a verdict.
// The parser reads the stored frame one byte per cycle through the buffer read port, taking
// one step per byte of the command prefix, id digits and payload digits walked, plus the
// step that finds their end. Overlong frames, and outside raw mode frames of terminators
// only, skip the walk. A stalled result register holds the parser at its final step;
// loading continues until both buffers are occupied. Reset clears the byte counter, the
// job queue, the result register and the quiet time bit; buffer contents are not cleared.
module command_frame_sanitizer import cfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [BYTE_W-1:0] req_frame_byte,
   input  logic              req_last_byte,
   input  logic              req_raw_mode,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [KEPT_W-1:0] rsp_kept_length,
   output logic              rsp_append_newline,
   output logic              rsp_trimmed,
   output logic              rsp_display_motion,
   output logic              rsp_suppressed,
   output logic              rsp_dropped,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);

   logic              quiet_ff, quiet_in;
   logic              q_full;
   logic              q_valid;
   logic              job_push;
   logic              job_pop;
   job_type           job_in;
   job_type           job_head;
   logic [JQ_PW-1:0]  head_slot;
   logic [JQ_PW-1:0]  tail_slot;
   logic [MEM_AW-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   assign csr_ready = 1'b1;
   assign quiet_in  = (csr_valid && csr_ready) ? csr_wdata : quiet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff <= 1'b0;
      end else begin
         quiet_ff <= quiet_in;
      end
   end

   cfs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .req_raw_mode   (req_raw_mode),
      .q_full         (q_full),
      .wr_slot        (tail_slot),
      .job_push       (job_push),
      .job_out        (job_in),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   cfs_job_fifo u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (job_in),
      .full      (q_full),
      .tail_slot (tail_slot),
      .pop       (job_pop),
      .valid     (q_valid),
      .head_job  (job_head),
      .head_slot (head_slot)
   );

   cfs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .quiet_time         (quiet_ff),
      .job_valid          (q_valid),
      .job                (job_head),
      .job_slot           (head_slot),
      .job_pop            (job_pop),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kept_length    (rsp_kept_length),
      .rsp_append_newline (rsp_append_newline),
      .rsp_trimmed        (rsp_trimmed),
      .rsp_display_motion (rsp_display_motion),
      .rsp_suppressed     (rsp_suppressed),
      .rsp_dropped        (rsp_dropped)
   );

endmodule

// File: verif/frame_verdict_checker.sv
module frame_verdict_checker import cfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic [BYTE_W-1:0] req_frame_byte,
   input  logic              req_last_byte,
   input  logic              req_raw_mode,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [KEPT_W-1:0] rsp_kept_length,
   input  logic              rsp_append_newline,
   input  logic              rsp_trimmed,
   input  logic              rsp_display_motion,
   input  logic              rsp_suppressed,
   input  logic              rsp_dropped,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_wdata,
   output int                mismatch_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KEPT_W-1:0] kept_length;
      logic              append_newline;
      logic              trimmed;
      logic              display_motion;
      logic              suppressed;
      logic              dropped;
   } verdict_type;

   logic [BYTE_W-1:0] frame_buf [MAX_FRAME_BYTES];
   int                fill_count;
   bit                overflow;
   bit                quiet_on;
   verdict_type       expected_verdicts [$];

   function automatic bit numeral(int i);
      return frame_buf[i] >= CH_0 && frame_buf[i] <= CH_9;
   endfunction

   function automatic bit terminator(int i);
      return frame_buf[i] == CH_LF || frame_buf[i] == CH_CR;
   endfunction

   // Walks the device id that starts at index 1. The value saturates, so any id
   // past the largest legal one is rejected no matter how many digits it has.
   function automatic bit parse_id(int len, output int pos, output bit wild);
      int i;
      int value;
      wild = 1'b0;
      pos  = 0;
      if (frame_buf[1] == CH_STAR) begin
         wild = 1'b1;
         pos  = 2;
         return 1'b1;
      end
      if (!numeral(1))
         return 1'b0;
      i = 1;
      value = 0;
      while (i < len && numeral(i)) begin
         value = value * 10 + int'(frame_buf[i] - CH_0);
         if (value > int'(ID_SAT))
            value = int'(ID_SAT);
         i++;
      end
      if (value > int'(ID_MAX))
         return 1'b0;
      pos = i;
      return 1'b1;
   endfunction

   // Command byte of an addressed frame, or zero when there is none.
   function automatic logic [BYTE_W-1:0] command_at(int len, output int pos, output bit wild);
      pos  = 0;
      wild = 1'b0;
      if (len < 3 || frame_buf[0] != CH_M || frame_buf[1] == CH_X)
         return '0;
      if (!parse_id(len, pos, wild) || pos >= len)
         return '0;
      return frame_buf[pos];
   endfunction

   function automatic verdict_type shape_frame(int len, bit raw, bit ovf);
      verdict_type       v;
      int                bare;
      int                pre;
      int                pos;
      int                d;
      int                p;
      bit                wild;
      logic [BYTE_W-1:0] cmd;
      v = '0;
      if (ovf) begin
         v.dropped = 1'b1;
         return v;
      end
      bare = len;
      if (!raw) begin
         while (bare > 0 && terminator(bare - 1))
            bare--;
         if (bare == 0) begin
            v.dropped = 1'b1;
            return v;
         end
         pre = bare;
         // Cut the frame right after the first complete known command.
         if (bare >= 2 && frame_buf[0] == CH_M && frame_buf[1] != CH_X &&
             parse_id(bare, pos, wild) && pos < bare) begin
            cmd = frame_buf[pos];
            pos++;
            case (cmd)
               CH_H, CH_C, CH_D: bare = pos;
               CH_V, CH_UA: if (!wild) bare = pos;
               CH_DASH: bare = (pos < bare) ? pos + 1 : pos;
               CH_PLUS, CH_O, CH_T, CH_S, CH_G, CH_LA, CH_I: begin
                  d = pos;
                  while (d < bare && numeral(d))
                     d++;
                  if (d != pos)
                     bare = d;
               end
               CH_W: begin
                  d = pos;
                  while (d < bare && numeral(d))
                     d++;
                  if (d != pos && d < bare && frame_buf[d] == CH_COLON) begin
                     d++;
                     p = d;
                     while (d < bare && numeral(d))
                        d++;
                     if (d != p)
                        bare = d;
                  end
               end
               default: ;
            endcase
         end
         v.trimmed = bare < pre;
         cmd = command_at(bare, pos, wild);
         v.append_newline = !(cmd == CH_V && !wild && pos + 1 == bare);
      end
      cmd = command_at(bare, pos, wild);
      if (cmd == CH_DASH || cmd == CH_PLUS)
         v.display_motion = 1'b1;
      else if (cmd == CH_H) begin
         if (pos + 1 >= bare)
            v.display_motion = 1'b1;
         else
            v.display_motion = terminator(pos + 1);
      end
      v.kept_length = bare[KEPT_W-1:0];
      v.suppressed  = v.display_motion && quiet_on;
      return v;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         fill_count = 0;
         overflow   = 1'b0;
         quiet_on   = 1'b0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready)
            quiet_on = csr_wdata;
         if (req_push && !req_full) begin
            if (fill_count < MAX_FRAME_BYTES) begin
               frame_buf[fill_count] = req_frame_byte;
               fill_count++;
            end else begin
               overflow = 1'b1;
            end
            if (req_last_byte) begin
               expected_verdicts.push_back(shape_frame(fill_count, req_raw_mode, overflow));
               fill_count = 0;
               overflow   = 1'b0;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict transfer with no frame waiting, expected none, actual %0d",
                        $time, rsp_kept_length);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("kept_length", want.kept_length, rsp_kept_length);
               check_field("append_newline", want.append_newline, rsp_append_newline);
               check_field("trimmed", want.trimmed, rsp_trimmed);
               check_field("display_motion", want.display_motion, rsp_display_motion);
               check_field("suppressed", want.suppressed, rsp_suppressed);
               check_field("dropped", want.dropped, rsp_dropped);
            end
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cfs_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 140;
   localparam int PHASE_BYTES   = 300;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic [BYTE_W-1:0] req_frame_byte;
   logic              req_last_byte;
   logic              req_raw_mode;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [KEPT_W-1:0] rsp_kept_length;
   logic              rsp_append_newline;
   logic              rsp_trimmed;
   logic              rsp_display_motion;
   logic              rsp_suppressed;
   logic              rsp_dropped;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_wdata;

   int                mismatch_count;
   int                pending;
   int unsigned       cycle_count = 0;
   int                bytes_sent = 0;
   bit                steady;
   logic [BYTE_W-1:0] frame_q [$];

   command_frame_sanitizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_frame_byte     (req_frame_byte),
      .req_last_byte      (req_last_byte),
      .req_raw_mode       (req_raw_mode),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kept_length    (rsp_kept_length),
      .rsp_append_newline (rsp_append_newline),
      .rsp_trimmed        (rsp_trimmed),
      .rsp_display_motion (rsp_display_motion),
      .rsp_suppressed     (rsp_suppressed),
      .rsp_dropped        (rsp_dropped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   frame_verdict_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_frame_byte     (req_frame_byte),
      .req_last_byte      (req_last_byte),
      .req_raw_mode       (req_raw_mode),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kept_length    (rsp_kept_length),
      .rsp_append_newline (rsp_append_newline),
      .rsp_trimmed        (rsp_trimmed),
      .rsp_display_motion (rsp_display_motion),
      .rsp_suppressed     (rsp_suppressed),
      .rsp_dropped        (rsp_dropped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish, %0d verdicts outstanding", $time, pending);
         $display("status: fail");
         $finish;
      end
   end

   // The verdict side stalls now and then, except during the steady stretch.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= steady || ($urandom_range(0, 99) >= 8);
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         frame_q.push_back(s[i]);
   endtask

   task automatic add_fill(int n);
      repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_digits(int n);
      repeat (n) frame_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_terms(int n);
      repeat (n) frame_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   task automatic send_byte(logic [BYTE_W-1:0] b, bit last, bit raw);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 8) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_frame_byte <= b;
      req_last_byte  <= last;
      req_raw_mode   <= raw;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Raw mode only matters on the last byte, so the other bytes carry noise there.
   task automatic send_frame(bit raw);
      int last_idx;
      last_idx = frame_q.size() - 1;
      for (int i = 0; i <= last_idx; i++)
         send_byte(frame_q[i], i == last_idx, (i == last_idx) ? raw : 1'($urandom_range(0, 1)));
      frame_q.delete();
   endtask

   task automatic send_text(string s, bit raw);
      add_text(s);
      send_frame(raw);
   endtask

   task automatic set_quiet(bit value);
      @(negedge clock);
      req_push <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly addressed commands with random ids, payloads, junk tails and
   // terminators; the rest is noise, bare terminators, stubs and long frames.
   task automatic random_frame();
      logic [BYTE_W-1:0] cmds [14];
      logic [BYTE_W-1:0] cmd;
      int                kind;
      int                r;
      bit                raw;
      cmds = '{CH_H, CH_C, CH_D, CH_V, CH_UA, CH_DASH, CH_PLUS,
               CH_O, CH_T, CH_S, CH_G, CH_LA, CH_I, CH_W};
      raw  = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         frame_q.push_back(CH_M);
         r = $urandom_range(0, 99);
         if (r < 10)
            frame_q.push_back(CH_STAR);
         else if (r < 14)
            frame_q.push_back(CH_X);
         else if (r < 24)
            add_text($sformatf("%0d", $urandom_range(255, 99999)));
         else if (r < 30)
            add_text($sformatf("%03d", $urandom_range(0, 254)));
         else
            add_text($sformatf("%0d", $urandom_range(0, 254)));
         cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : cmds[$urandom_range(0, 13)];
         frame_q.push_back(cmd);
         if (cmd == CH_W) begin
            add_digits($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
               frame_q.push_back(CH_COLON);
            add_digits($urandom_range(0, 3));
         end else if (cmd == CH_DASH) begin
            if ($urandom_range(0, 3) != 0)
               add_fill(1);
         end else begin
            add_digits($urandom_range(0, 4));
         end
         if ($urandom_range(0, 2) == 0)
            add_fill($urandom_range(1, 4));
         if ($urandom_range(0, 9) < 4)
            add_terms($urandom_range(1, 3));
      end else if (kind < 82) begin
         add_fill($urandom_range(1, 8));
      end else if (kind < 88) begin
         add_terms($urandom_range(1, 4));
      end else if (kind < 95) begin
         frame_q.push_back(CH_M);
         r = $urandom_range(0, 2);
         if (r == 1)
            add_digits(1);
         else if (r == 2)
            frame_q.push_back(CH_STAR);
         if ($urandom_range(0, 1) == 1)
            frame_q.push_back(cmds[$urandom_range(0, 13)]);
      end else begin
         // Lengths around the buffer size, so both sides of the overflow limit occur.
         add_text("m1+");
         add_fill($urandom_range(122, 127));
      end
      send_frame(raw);
   endtask

   initial begin
      int goal;
      req_push       = 1'b0;
      req_frame_byte = '0;
      req_last_byte  = 1'b0;
      req_raw_mode   = 1'b0;
      csr_valid      = 1'b0;
      csr_wdata      = 1'b0;
      steady         = 1'b0;
      reset          = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_text("m12h", 1'b0);
      send_text("m3h\r\n", 1'b0);
      send_text("m0h\rxyz", 1'b0);
      send_text("m12h\r\n", 1'b1);
      send_text("m12hq", 1'b1);
      send_text("m*v", 1'b0);
      send_text("m7v", 1'b0);
      send_text("m7vxyz\n", 1'b0);
      send_text("m7v", 1'b1);
      send_text("m*A9", 1'b0);
      send_text("m254-Q", 1'b0);
      send_text("m254-", 1'b0);
      send_text("m255-Q", 1'b0);
      send_text("m99999+12", 1'b0);
      send_text("m1+12abc", 1'b0);
      send_text("m5w12:34zz", 1'b0);
      send_text("m5w12x", 1'b0);
      send_text("mX7h", 1'b0);
      send_text("m1o", 1'b0);
      send_text("m", 1'b0);
      send_text("m1c\r", 1'b0);
      send_text("\r\n\r", 1'b0);
      send_text("\n", 1'b1);
      frame_q.push_back(8'h00);
      frame_q.push_back(8'hFF);
      send_frame(1'b0);
      // A frame that exactly fills the buffer, one that overflows it, and a raw full one.
      add_text("m1+");
      repeat (125) frame_q.push_back("x");
      send_frame(1'b0);
      add_text("m1+");
      repeat (126) frame_q.push_back("x");
      send_frame(1'b0);
      add_text("m2h");
      repeat (125) frame_q.push_back("\n");
      send_frame(1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         set_quiet(phase % 2 == 0);
         steady = (phase == 2);
         goal = bytes_sent + PHASE_BYTES;
         while (bytes_sent < goal)
            random_frame();
      end
      steady = 1'b0;

      @(negedge clock);
      req_push <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d verdicts never arrived", $time, pending);
      if (mismatch_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/cfs_pkg.sv
hw/rtl/cfs_job_fifo.sv
hw/rtl/cfs_front.sv
hw/rtl/cfs_back.sv
hw/rtl/command_frame_sanitizer.sv
verif/frame_verdict_checker.sv
verif/tb.sv
